/* rtl/core/slvg_pkg.sv */
package slvg_pkg;

   // table geometry
   localparam int TABLE_SIZE = 64;
   localparam int ADDR_W     = $clog2(TABLE_SIZE);
   localparam int COUNT_W    = $clog2(TABLE_SIZE + 1);

   // field widths
   localparam int COMP_W   = 20;
   localparam int BASIS_W  = 3 * COMP_W;
   localparam int CUT_W    = 26;
   localparam int RANGE_W  = 4;
   localparam int SPAN_W   = RANGE_W + 1;
   localparam int VEC_W    = 26;
   localparam int LEN_W    = 52;
   localparam int CSR_IDX_W = 3;
   localparam int INDEX_W  = 6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BASIS_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CUTOFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_Y = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_Z = 3'd6;

   // command codes
   localparam logic CMD_BUILD = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {SQ_X, SQ_Y, SQ_Z} sq_sel_type;
   typedef enum logic [2:0] {RD_NONE, RD_IDX, RD_INS, RD_KM1, RD_KM2} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_NEW} wr_sel_type;

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
   } vec3_type;

   typedef struct packed {
      vec3_type         v;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic       latch;
      logic       init;
      logic       mul_en;
      sq_sel_type mul_sel;
      logic       acc_load;
      logic       acc_add;
      logic       ins_start;
      logic       set_ovf;
      rd_sel_type rd_sel;
      wr_sel_type wr_sel;
      logic       k_dec;
      logic       next_point;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic keep;
      logic full;
      logic count_zero;
      logic ge;
      logic k_one;
      logic last_point;
   } status_type;

   // take one packed component of a basis register
   function automatic logic signed [COMP_W-1:0] comp_of(input logic [BASIS_W-1:0] r,
                                                        input int which);
      return r[which*COMP_W +: COMP_W];
   endfunction

   // coordinate of the first lattice point: -(nx*a + ny*b + nz*c)
   function automatic logic signed [VEC_W-1:0] base_coord(
         input logic [RANGE_W-1:0] nx, input logic [RANGE_W-1:0] ny,
         input logic [RANGE_W-1:0] nz, input logic signed [COMP_W-1:0] ca,
         input logic signed [COMP_W-1:0] cb, input logic signed [COMP_W-1:0] cc);
      logic signed [VEC_W-1:0] s;
      s = $signed(VEC_W'(nx)) * VEC_W'(ca) + $signed(VEC_W'(ny)) * VEC_W'(cb)
        + $signed(VEC_W'(nz)) * VEC_W'(cc);
      return -s;
   endfunction

endpackage

/* rtl/core/slvg_ctrl.sv */
module slvg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_command,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  slvg_pkg::status_type status,
   output slvg_pkg::cmd_type    cmd
);
   import slvg_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_RD, S_INIT, S_SQX, S_SQY, S_SQZ, S_SUM, S_TEST,
      S_FULL, S_SCAN, S_WRITE, S_NEXT, S_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_take, out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // decode commands and next state
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = SQ_X;
      cmd.rd_sel   = RD_NONE;
      cmd.wr_sel   = WR_NONE;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd.latch = 1'b1;
               state_in  = (req_command == CMD_READ) ? S_RD : S_INIT;
            end
         end
         S_RD: begin
            cmd.rd_sel = RD_IDX;
            state_in   = S_FIN;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_SQX;
         end
         S_SQX: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SQ_X;
            state_in    = S_SQY;
         end
         S_SQY: begin
            cmd.mul_en   = 1'b1;
            cmd.mul_sel  = SQ_Y;
            cmd.acc_load = 1'b1;
            state_in     = S_SQZ;
         end
         S_SQZ: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SQ_Z;
            cmd.acc_add = 1'b1;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.acc_add = 1'b1;
            state_in    = S_TEST;
         end
         S_TEST: begin
            if (!status.keep) begin
               state_in = S_NEXT;
            end else begin
               cmd.ins_start = 1'b1;
               cmd.rd_sel    = RD_INS;
               if (status.full) state_in = S_FULL;
               else if (status.count_zero) state_in = S_WRITE;
               else state_in = S_SCAN;
            end
         end
         S_FULL: begin
            cmd.set_ovf = 1'b1;
            if (status.ge) begin
               cmd.rd_sel = RD_KM1;
               state_in   = S_SCAN;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_SCAN: begin
            if (status.ge) begin
               cmd.wr_sel = WR_SHIFT;
               cmd.k_dec  = 1'b1;
               cmd.rd_sel = RD_KM2;
               if (status.k_one) state_in = S_WRITE;
            end else begin
               cmd.wr_sel = WR_NEW;
               state_in   = S_NEXT;
            end
         end
         S_WRITE: begin
            cmd.wr_sel = WR_NEW;
            state_in   = S_NEXT;
         end
         S_NEXT: begin
            if (status.last_point) begin
               state_in = S_FIN;
            end else begin
               cmd.next_point = 1'b1;
               state_in       = S_SQX;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff != S_IDLE)
      else $error("accepted word did not start work");
   a_fin_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && out_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished word not presented");
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && $past(state_ff) != S_SCAN) |->
      ($past(state_ff) == S_TEST || $past(state_ff) == S_FULL))
      else $error("scan entered from wrong state");
   a_no_stray_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && state_ff == S_FIN) |=> $stable(rsp_valid_ff))
      else $error("stalled response dropped");

endmodule

/* rtl/core/slvg_dp.sv */
module slvg_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [slvg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slvg_pkg::BASIS_W-1:0]        csr_data,
   input  logic                                req_command,
   input  logic [slvg_pkg::INDEX_W-1:0]        req_entry_index,
   input  slvg_pkg::cmd_type                   cmd,
   output slvg_pkg::status_type                status,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_x,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_y,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_z,
   output logic [slvg_pkg::LEN_W-1:0]          rsp_length_squared,
   output logic [slvg_pkg::COUNT_W-1:0]        rsp_stored_count,
   output logic                                rsp_table_overflow,
   output logic                                rsp_index_invalid
);
   import slvg_pkg::*;

   // configuration
   logic [BASIS_W-1:0] basis_a_ff, basis_b_ff, basis_c_ff;
   logic [CUT_W-1:0]   cutoff_ff;
   logic [RANGE_W-1:0] range_x_ff, range_y_ff, range_z_ff;

   // working registers
   logic                cmd_ff;
   logic [INDEX_W-1:0]  idx_ff;
   logic [SPAN_W-1:0]   ci_ff, cj_ff, ck_ff, ci_in, cj_in, ck_in;
   vec3_type            pi_ff, pj_ff, v_ff, pi_in, pj_in, v_in;
   logic [LEN_W-1:0]    mul_ff, acc_ff, acc_in;
   logic [LEN_W:0]      limit_ff;
   logic [ADDR_W-1:0]   k_ff, k_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                ovf_ff, ovf_in;

   // table memory
   entry_type           mem [TABLE_SIZE];
   entry_type           rd_ff, wr_data;
   logic                rd_en, wr_en;
   logic [ADDR_W-1:0]   rd_addr;

   vec3_type                a_v, b_v, c_v;
   logic signed [VEC_W-1:0] sq_comp;
   logic [VEC_W-1:0]        sq_mag;
   logic [LEN_W-1:0]        sq_full;
   logic [SPAN_W-1:0]       span_x, span_y, span_z;
   logic                    full, idx_ok;

   always_comb begin
      a_v.x = VEC_W'(comp_of(basis_a_ff, 0));
      a_v.y = VEC_W'(comp_of(basis_a_ff, 1));
      a_v.z = VEC_W'(comp_of(basis_a_ff, 2));
      b_v.x = VEC_W'(comp_of(basis_b_ff, 0));
      b_v.y = VEC_W'(comp_of(basis_b_ff, 1));
      b_v.z = VEC_W'(comp_of(basis_b_ff, 2));
      c_v.x = VEC_W'(comp_of(basis_c_ff, 0));
      c_v.y = VEC_W'(comp_of(basis_c_ff, 1));
      c_v.z = VEC_W'(comp_of(basis_c_ff, 2));
   end

   assign span_x = {range_x_ff, 1'b0};
   assign span_y = {range_y_ff, 1'b0};
   assign span_z = {range_z_ff, 1'b0};
   assign full   = (count_ff == COUNT_W'(TABLE_SIZE));
   assign idx_ok = ({1'b0, idx_ff} < count_ff);

   // status back to the controller
   assign status.is_read    = (cmd_ff == CMD_READ);
   assign status.keep       = ({1'b0, acc_ff} <= limit_ff);
   assign status.full       = full;
   assign status.count_zero = (count_ff == '0);
   assign status.ge         = (rd_ff.len >= acc_ff);
   assign status.k_one      = (k_ff == ADDR_W'(1));
   assign status.last_point = (ci_ff == span_x) && (cj_ff == span_y) && (ck_ff == span_z);

   // square the magnitude of one component
   always_comb begin
      case (cmd.mul_sel)
         SQ_X:    sq_comp = v_ff.x;
         SQ_Y:    sq_comp = v_ff.y;
         SQ_Z:    sq_comp = v_ff.z;
         default: sq_comp = v_ff.x;
      endcase
      sq_mag  = sq_comp[VEC_W-1] ? VEC_W'(-sq_comp) : VEC_W'(sq_comp);
      sq_full = LEN_W'(sq_mag) * LEN_W'(sq_mag);
   end

   // walk the lattice, accumulate length, track table fill
   always_comb begin
      ci_in    = ci_ff;
      cj_in    = cj_ff;
      ck_in    = ck_ff;
      pi_in    = pi_ff;
      pj_in    = pj_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.init) begin
         ci_in    = '0;
         cj_in    = '0;
         ck_in    = '0;
         pi_in.x  = base_coord(range_x_ff, range_y_ff, range_z_ff, a_v.x[COMP_W-1:0],
                               b_v.x[COMP_W-1:0], c_v.x[COMP_W-1:0]);
         pi_in.y  = base_coord(range_x_ff, range_y_ff, range_z_ff, a_v.y[COMP_W-1:0],
                               b_v.y[COMP_W-1:0], c_v.y[COMP_W-1:0]);
         pi_in.z  = base_coord(range_x_ff, range_y_ff, range_z_ff, a_v.z[COMP_W-1:0],
                               b_v.z[COMP_W-1:0], c_v.z[COMP_W-1:0]);
         pj_in    = pi_in;
         v_in     = pi_in;
         count_in = '0;
         ovf_in   = 1'b0;
      end
      if (cmd.next_point) begin
         if (ck_ff != span_z) begin
            ck_in  = ck_ff + SPAN_W'(1);
            v_in.x = v_ff.x + c_v.x;
            v_in.y = v_ff.y + c_v.y;
            v_in.z = v_ff.z + c_v.z;
         end else if (cj_ff != span_y) begin
            ck_in   = '0;
            cj_in   = cj_ff + SPAN_W'(1);
            pj_in.x = pj_ff.x + b_v.x;
            pj_in.y = pj_ff.y + b_v.y;
            pj_in.z = pj_ff.z + b_v.z;
            v_in    = pj_in;
         end else begin
            ck_in   = '0;
            cj_in   = '0;
            ci_in   = ci_ff + SPAN_W'(1);
            pi_in.x = pi_ff.x + a_v.x;
            pi_in.y = pi_ff.y + a_v.y;
            pi_in.z = pi_ff.z + a_v.z;
            pj_in   = pi_in;
            v_in    = pi_in;
         end
      end
      if (cmd.acc_load) acc_in = mul_ff;
      if (cmd.acc_add)  acc_in = acc_ff + mul_ff;
      if (cmd.ins_start) begin
         if (full) begin
            k_in = ADDR_W'(TABLE_SIZE - 1);
         end else begin
            k_in     = count_ff[ADDR_W-1:0];
            count_in = count_ff + COUNT_W'(1);
         end
      end
      if (cmd.k_dec)   k_in   = k_ff - ADDR_W'(1);
      if (cmd.set_ovf) ovf_in = 1'b1;
   end

   // pick memory read and write
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = k_ff;
      case (cmd.rd_sel)
         RD_IDX:  rd_addr = idx_ff;
         RD_INS:  rd_addr = full ? ADDR_W'(TABLE_SIZE - 1) : ADDR_W'(count_ff - COUNT_W'(1));
         RD_KM1:  rd_addr = k_ff - ADDR_W'(1);
         RD_KM2:  rd_addr = k_ff - ADDR_W'(2);
         default: rd_en   = 1'b0;
      endcase
      wr_en     = (cmd.wr_sel != WR_NONE);
      wr_data.v = v_ff;
      wr_data.len = acc_ff;
      if (cmd.wr_sel == WR_SHIFT) wr_data = rd_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[k_ff] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // hold configuration and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         basis_a_ff <= '0;
         basis_b_ff <= '0;
         basis_c_ff <= '0;
         cutoff_ff  <= '0;
         range_x_ff <= '0;
         range_y_ff <= '0;
         range_z_ff <= '0;
         count_ff   <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_BASIS_A: basis_a_ff <= csr_data;
               REG_BASIS_B: basis_b_ff <= csr_data;
               REG_BASIS_C: basis_c_ff <= csr_data;
               REG_CUTOFF:  cutoff_ff  <= csr_data[CUT_W-1:0];
               REG_RANGE_X: range_x_ff <= csr_data[RANGE_W-1:0];
               REG_RANGE_Y: range_y_ff <= csr_data[RANGE_W-1:0];
               REG_RANGE_Z: range_z_ff <= csr_data[RANGE_W-1:0];
               default: ;
            endcase
         end
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   // advance the datapath
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff <= req_command;
         idx_ff <= req_entry_index;
      end
      if (cmd.init) limit_ff <= {1'b0, LEN_W'(cutoff_ff) * LEN_W'(cutoff_ff)} + (LEN_W+1)'(1);
      if (cmd.mul_en) mul_ff <= sq_full;
      ci_ff  <= ci_in;
      cj_ff  <= cj_in;
      ck_ff  <= ck_in;
      pi_ff  <= pi_in;
      pj_ff  <= pj_in;
      v_ff   <= v_in;
      acc_ff <= acc_in;
      k_ff   <= k_in;
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_stored_count   <= count_ff;
         rsp_table_overflow <= ovf_ff;
         rsp_index_invalid  <= (cmd_ff == CMD_READ) && !idx_ok;
         if ((cmd_ff == CMD_READ) && idx_ok) begin
            rsp_vector_x       <= rd_ff.v.x;
            rsp_vector_y       <= rd_ff.v.y;
            rsp_vector_z       <= rd_ff.v.z;
            rsp_length_squared <= rd_ff.len;
         end else begin
            rsp_vector_x       <= '0;
            rsp_vector_y       <= '0;
            rsp_vector_z       <= '0;
            rsp_length_squared <= '0;
         end
      end
   end

endmodule

/* rtl/core/sorted_lattice_vector_generator.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | command, entry_index
// rsp     | out       | rsp_valid/rsp_stall  | vector_x/y/z, length_squared, count, flags
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A read passes through S_RD and S_FIN before its result is presented; the next word is
// taken once the controller is back in S_IDLE. A build visits S_SQX to S_SQZ, S_SUM,
// S_TEST and S_NEXT per lattice point (the squaring multiplier is shared by the three
// components), plus per kept vector a write, a shift per entry moved and, if full, S_FULL.
// Reset is synchronous and clears control state, the configuration registers, the
// count and the overflow flag; the table is not cleared, only entries below the count
// are ever returned. A result stalled at the output holds the next finished word back.
module sorted_lattice_vector_generator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [slvg_pkg::INDEX_W-1:0]        req_entry_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_x,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_y,
   output logic signed [slvg_pkg::VEC_W-1:0]   rsp_vector_z,
   output logic [slvg_pkg::LEN_W-1:0]          rsp_length_squared,
   output logic [slvg_pkg::COUNT_W-1:0]        rsp_stored_count,
   output logic                                rsp_table_overflow,
   output logic                                rsp_index_invalid,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [slvg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [slvg_pkg::BASIS_W-1:0]        csr_data
);
   import slvg_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   slvg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   slvg_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_command        (req_command),
      .req_entry_index    (req_entry_index),
      .cmd                (cmd),
      .status             (status),
      .rsp_vector_x       (rsp_vector_x),
      .rsp_vector_y       (rsp_vector_y),
      .rsp_vector_z       (rsp_vector_z),
      .rsp_length_squared (rsp_length_squared),
      .rsp_stored_count   (rsp_stored_count),
      .rsp_table_overflow (rsp_table_overflow),
      .rsp_index_invalid  (rsp_index_invalid)
   );

endmodule

/* tb/tb_sorted_lattice_vector_generator.sv */
module tb_sorted_lattice_vector_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import slvg_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic signed [VEC_W-1:0] vx;
      logic signed [VEC_W-1:0] vy;
      logic signed [VEC_W-1:0] vz;
      logic [LEN_W-1:0]        len;
      logic [COUNT_W-1:0]      count;
      logic                    ovf;
      logic                    inv;
   } lattice_word_type;

   typedef struct {
      int               cfg_set;
      logic             cmd;
      logic [INDEX_W-1:0] idx;
      bit               typed;
      lattice_word_type want;
   } directed_row_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = CMD_BUILD;
   logic [INDEX_W-1:0] req_entry_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [VEC_W-1:0] rsp_vector_x, rsp_vector_y, rsp_vector_z;
   logic [LEN_W-1:0] rsp_length_squared;
   logic [COUNT_W-1:0] rsp_stored_count;
   logic rsp_table_overflow, rsp_index_invalid;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BASIS_W-1:0] csr_data = '0;

   sorted_lattice_vector_generator dut (.*);

   // predictor copy of registers and table
   logic [BASIS_W-1:0] lat_a, lat_b, lat_c;
   logic [CUT_W-1:0]   lat_cutoff;
   logic [RANGE_W-1:0] lat_rx, lat_ry, lat_rz;
   logic signed [VEC_W-1:0] tab_x [TABLE_SIZE];
   logic signed [VEC_W-1:0] tab_y [TABLE_SIZE];
   logic signed [VEC_W-1:0] tab_z [TABLE_SIZE];
   logic [LEN_W-1:0]        tab_len [TABLE_SIZE];
   longint unsigned         tab_exact [TABLE_SIZE];
   int  tab_count;
   bit  tab_dropped;

   lattice_word_type pending_words[$];
   int  mismatches, builds, reads, bad_reads, full_builds;
   bit  quiet = 0;
   bit  hold_req = 0;
   int  hold_cnt = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("[sorted_lattice_vector_generator] ERROR");
      $finish;
   end

   function automatic longint basis_comp(input logic [BASIS_W-1:0] r, input int which);
      logic signed [COMP_W-1:0] c;
      c = r[which*COMP_W +: COMP_W];
      return longint'(c);
   endfunction

   function automatic logic signed [VEC_W-1:0] clamp_vec(input longint v);
      longint hi;
      hi = (longint'(1) <<< (VEC_W-1)) - 1;
      if (v > hi) v = hi;
      if (v < -hi - 1) v = -hi - 1;
      return v[VEC_W-1:0];
   endfunction

   // insert one kept vector, nearer first, ahead of equal lengths
   function automatic void sort_in(input longint vx, input longint vy, input longint vz,
                                   input longint unsigned len);
      int pos, last;
      pos = 0;
      while (pos < tab_count && tab_exact[pos] < len) pos++;
      if (tab_count >= TABLE_SIZE) begin
         tab_dropped = 1;
         if (pos >= TABLE_SIZE) return;
         last = TABLE_SIZE - 1;
      end else begin
         last = tab_count;
         tab_count++;
      end
      for (int k = last; k > pos; k--) begin
         tab_x[k] = tab_x[k-1];
         tab_y[k] = tab_y[k-1];
         tab_z[k] = tab_z[k-1];
         tab_len[k] = tab_len[k-1];
         tab_exact[k] = tab_exact[k-1];
      end
      tab_x[pos] = clamp_vec(vx);
      tab_y[pos] = clamp_vec(vy);
      tab_z[pos] = clamp_vec(vz);
      tab_len[pos] = (len >> LEN_W) != 0 ? '1 : len[LEN_W-1:0];
      tab_exact[pos] = len;
   endfunction

   function automatic void rebuild_table();
      longint a[3], b[3], c[3], v[3];
      longint unsigned len, limit;
      int nx, ny, nz;
      for (int n = 0; n < 3; n++) begin
         a[n] = basis_comp(lat_a, n);
         b[n] = basis_comp(lat_b, n);
         c[n] = basis_comp(lat_c, n);
      end
      nx = lat_rx; ny = lat_ry; nz = lat_rz;
      limit = longint'(lat_cutoff) * longint'(lat_cutoff) + 1;
      tab_count = 0;
      tab_dropped = 0;
      for (int i = -nx; i <= nx; i++)
         for (int j = -ny; j <= ny; j++)
            for (int k = -nz; k <= nz; k++) begin
               len = 0;
               for (int n = 0; n < 3; n++) begin
                  v[n] = i * a[n] + j * b[n] + k * c[n];
                  len += longint'(v[n] * v[n]);
               end
               if (len <= limit) sort_in(v[0], v[1], v[2], len);
            end
   endfunction

   function automatic lattice_word_type predict_word(input logic cmd,
                                                     input logic [INDEX_W-1:0] idx);
      lattice_word_type w;
      w = '0;
      if (cmd == CMD_BUILD) begin
         rebuild_table();
         builds++;
         if (tab_dropped) full_builds++;
      end else begin
         reads++;
         if (idx < tab_count) begin
            w.vx = tab_x[idx];
            w.vy = tab_y[idx];
            w.vz = tab_z[idx];
            w.len = tab_len[idx];
         end else begin
            w.inv = 1;
            bad_reads++;
         end
      end
      w.count = COUNT_W'(tab_count);
      w.ovf = tab_dropped;
      return w;
   endfunction

   // write one register, then drop valid for a cycle
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BASIS_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         REG_BASIS_A: lat_a = data;
         REG_BASIS_B: lat_b = data;
         REG_BASIS_C: lat_c = data;
         REG_CUTOFF:  lat_cutoff = data[CUT_W-1:0];
         REG_RANGE_X: lat_rx = data[RANGE_W-1:0];
         REG_RANGE_Y: lat_ry = data[RANGE_W-1:0];
         REG_RANGE_Z: lat_rz = data[RANGE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [BASIS_W-1:0] a, input logic [BASIS_W-1:0] b,
                            input logic [BASIS_W-1:0] c, input logic [CUT_W-1:0] cut,
                            input int rx, input int ry, input int rz);
      write_reg(REG_BASIS_A, a);
      write_reg(REG_BASIS_B, b);
      write_reg(REG_BASIS_C, c);
      write_reg(REG_CUTOFF, BASIS_W'(cut));
      write_reg(REG_RANGE_X, BASIS_W'(rx));
      write_reg(REG_RANGE_Y, BASIS_W'(ry));
      write_reg(REG_RANGE_Z, BASIS_W'(rz));
   endtask

   // offer one word, holding it until accepted
   task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                            input bit typed, input lattice_word_type want);
      lattice_word_type w;
      while (!quiet && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_entry_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      w = predict_word(cmd, idx);
      pending_words.push_back(typed ? want : w);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COMP_W-1:0] rand_comp(input bit narrow);
      logic [COMP_W-1:0] c;
      c = COMP_W'($urandom());
      if (narrow) c = COMP_W'($signed(c[12:0]));
      return c;
   endfunction

   function automatic logic [BASIS_W-1:0] rand_basis(input bit narrow);
      return {rand_comp(narrow), rand_comp(narrow), rand_comp(narrow)};
   endfunction

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_req) begin
         rsp_stall <= 1'b1;
         hold_cnt <= HOLD_CYCLES;
      end else if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt - 1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 23);
      end
   end

   // compare each accepted result word with the oldest expectation
   always @(posedge clock) begin
      lattice_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_vector_x, rsp_vector_y, rsp_vector_z, rsp_length_squared,
                rsp_stored_count, rsp_table_overflow, rsp_index_invalid};
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %h", got);
         end else begin
            want = pending_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp x=%0d y=%0d z=%0d len=%h n=%0d ovf=%b inv=%b",
                           want.vx, want.vy, want.vz, want.len, want.count, want.ovf,
                           want.inv);
                  $display("          got x=%0d y=%0d z=%0d len=%h n=%0d ovf=%b inv=%b",
                           got.vx, got.vy, got.vz, got.len, got.count, got.ovf,
                           got.inv);
               end
            end
         end
      end
   end

   initial begin
      directed_row_type rows[$];
      directed_row_type r;
      lattice_word_type z;
      logic [BASIS_W-1:0] ext_a, ext_b, ext_c;
      int cur_set;
      logic cmd;
      logic [INDEX_W-1:0] idx;

      z = '0;
      lat_a = '0; lat_b = '0; lat_c = '0; lat_cutoff = '0;
      lat_rx = '0; lat_ry = '0; lat_rz = '0;
      tab_count = 0; tab_dropped = 0;
      mismatches = 0; builds = 0; reads = 0; bad_reads = 0; full_builds = 0;

      // reset state: empty table, then origin only
      r = '{0, CMD_READ, 6'd0, 1, z}; r.want.inv = 1; rows.push_back(r);
      r = '{0, CMD_BUILD, 6'd63, 1, z}; r.want.count = 1; rows.push_back(r);
      r = '{0, CMD_READ, 6'd0, 1, z}; r.want.count = 1; rows.push_back(r);
      r = '{0, CMD_READ, 6'd63, 1, z}; r.want.count = 1; r.want.inv = 1; rows.push_back(r);
      // axis-aligned basis of length 1024, widest cutoff: full table with many ties
      r = '{1, CMD_BUILD, 6'd0, 1, z}; r.want.count = 64; r.want.ovf = 1; rows.push_back(r);
      r = '{1, CMD_READ, 6'd0, 0, z}; rows.push_back(r);
      r = '{1, CMD_READ, 6'd1, 0, z}; rows.push_back(r);
      r = '{1, CMD_READ, 6'd7, 0, z}; rows.push_back(r);
      r = '{1, CMD_READ, 6'd63, 0, z}; rows.push_back(r);
      // extreme components on a long axis
      r = '{2, CMD_BUILD, 6'd21, 0, z}; rows.push_back(r);
      r = '{2, CMD_READ, 6'd0, 0, z}; rows.push_back(r);
      r = '{2, CMD_READ, 6'd30, 0, z}; rows.push_back(r);
      r = '{2, CMD_READ, 6'd63, 0, z}; rows.push_back(r);
      // zero cutoff keeps only short vectors
      r = '{3, CMD_BUILD, 6'd42, 0, z}; rows.push_back(r);
      r = '{3, CMD_READ, 6'd0, 0, z}; rows.push_back(r);
      r = '{3, CMD_READ, 6'd1, 0, z}; rows.push_back(r);
      r = '{3, CMD_READ, 6'd62, 0, z}; rows.push_back(r);

      ext_a = {20'h00001, 20'h7FFFF, 20'h80000};
      ext_b = {20'h80000, 20'h80000, 20'h7FFFF};
      ext_c = {20'h7FFFF, 20'h00000, 20'hFFFFF};

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_set = 0;
      foreach (rows[n]) begin
         if (rows[n].cfg_set != cur_set) begin
            drain();
            cur_set = rows[n].cfg_set;
            case (cur_set)
               1: write_all({20'd0, 20'd0, 20'd1024}, {20'd0, 20'd1024, 20'd0},
                            {20'd1024, 20'd0, 20'd0}, '1, 2, 2, 2);
               2: write_all(ext_a, ext_b, ext_c, '1, 15, 0, 1);
               default: begin
                  write_all({20'd0, 20'd0, 20'd1}, ext_b, ext_c, '0, 15, 0, 0);
                  write_reg(REG_UNUSED, '1);
               end
            endcase
         end
         send_word(rows[n].cmd, rows[n].idx, rows[n].typed, rows[n].want);
      end

      // random phases, each with its own register setting
      for (int ph = 0; ph < 10; ph++) begin
         bit narrow;
         drain();
         quiet = (ph == 5);
         narrow = ($urandom_range(3) != 0);
         if ($urandom_range(4) == 0)
            write_all(rand_basis(narrow), rand_basis(narrow), rand_basis(narrow),
                      CUT_W'($urandom()), $urandom_range(15), 0, 0);
         else
            write_all(rand_basis(narrow), rand_basis(narrow), rand_basis(narrow),
                      narrow ? CUT_W'($urandom_range(20000)) : CUT_W'($urandom()),
                      $urandom_range(3), $urandom_range(3), $urandom_range(2));
         for (int n = 0; n < 12; n++) begin
            if (ph == 3 && n == 2) begin
               hold_req <= 1'b1;
               @(posedge clock);
               hold_req <= 1'b0;
            end
            if (n == 0 || $urandom_range(99) < 12) cmd = CMD_BUILD;
            else cmd = CMD_READ;
            if ($urandom_range(1)) idx = INDEX_W'($urandom());
            else idx = INDEX_W'($urandom_range(tab_count + 3 > 63 ? 63 : tab_count + 3));
            send_word(cmd, idx, 0, z);
         end
      end

      drain();
      $display("covered %0d builds (%0d overflowed) and %0d reads (%0d out of range)",
               builds, full_builds, reads, bad_reads);
      $display("mismatches: %0d", mismatches);
      if (mismatches == 0)
         $display("[sorted_lattice_vector_generator] OK");
      else
         $display("[sorted_lattice_vector_generator] ERROR");
      $finish;
   end

endmodule

/* sim.f */
rtl/core/slvg_pkg.sv
rtl/core/slvg_ctrl.sv
rtl/core/slvg_dp.sv
rtl/core/sorted_lattice_vector_generator.sv
tb/tb_sorted_lattice_vector_generator.sv
